@@ sv/fbpa_pkg.sv @@
`default_nettype none

package fbpa_pkg;

    // Pool geometry
    localparam int NUM_SLOTS  = 32;
    localparam int SLOT_BYTES = 348;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Field widths
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int OUT_IDX_W  = 5;
    localparam int OCC_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_LARGE   = 3'd1,
        ST_NO_MEMORY   = 3'd2,
        ST_DOUBLE_FREE = 3'd3,
        ST_INVALID     = 3'd4
    } status_t;

    typedef logic [NUM_SLOTS-1:0]  slot_map_t;
    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

    typedef struct packed {
        func_t             func;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [ADDR_W-1:0]    slot_address;
        logic [OUT_IDX_W-1:0] slot_index;
        logic [OCC_W-1:0]     occupancy_map;
    } res_t;

    // Byte offset of a slot from the pool base; constant per slot index.
    function automatic logic [ADDR_W-1:0] slot_offset(input slot_idx_t idx);
        return ADDR_W'(idx) * ADDR_W'(SLOT_BYTES);
    endfunction

endpackage

`default_nettype wire

@@ sv/fixed_block_pool_allocator.sv @@
// Fixed block pool allocator: hands out and takes back equal-sized slots of a
// buffer pool, one in-use flag per slot.
// Channels: s_ carries requests (tuser = operation: allocate or free, tdata =
// request size and block address); m_ carries one result per request (status,
// granted slot address, slot index, occupancy map after the request).
// pool_base is set through the APB port; write it only while no request is
// in flight. Slot i lies at pool_base + i * slot size.
// A request passes through the input register and then the result register
// before its result shows on m_.
// Throughput: one request per cycle while m_ is not stalled, set by the flag
// register, which takes each request's update in the single cycle the request
// leaves the input register; the next request sees the updated flags directly.
// Reset: every slot free, pool_base zero, both channels empty.
// Receiver stall: the result register holds its transaction; the input
// register takes one more request, then s_tready drops until m_tready returns.
`default_nettype none

module fixed_block_pool_allocator (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [47:0]                      s_tdata,  // [15:0] request_size,
                                                       // [47:16] block_address
    input  logic [0:0]                       s_tuser,  // [0] func
    // Result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [71:0]                      m_tdata,  // [2:0] status,
                                                       // [34:3] slot_address,
                                                       // [39:35] slot_index,
                                                       // [71:40] occupancy_map
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fbpa_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [fbpa_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import fbpa_pkg::*;

    logic              in_valid_reg;
    req_t              in_req_reg;
    logic              out_valid_reg;
    res_t              out_res_reg;
    logic              advance;
    res_t              core_res;
    logic [ADDR_W-1:0] pool_base;

    fbpa_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pool_base (pool_base)
    );

    // Move the held request into the result register when that register is
    // empty or being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register: capture a request transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg.func          <= func_t'(s_tuser[0]);
            in_req_reg.request_size  <= s_tdata[15:0];
            in_req_reg.block_address <= s_tdata[47:16];
        end
    end

    // Slot search and flag update
    fbpa_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .req       (in_req_reg),
        .pool_base (pool_base),
        .res       (core_res)
    );

    // Result register: hold until the receiver takes the transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.occupancy_map, out_res_reg.slot_index,
                       out_res_reg.slot_address, out_res_reg.status};

    // The request side only stalls when a result is waiting and not taken
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("request side stalled without a blocked result");

    // A granted slot shows as in use in the reported map
    a_alloc_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_req_reg.func == FUNC_ALLOC && core_res.status == ST_OK)
        |-> core_res.occupancy_map[core_res.slot_index])
        else $error("allocated slot not marked in use");

    // A released slot shows as free in the reported map
    a_free_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_req_reg.func == FUNC_FREE && core_res.status == ST_OK)
        |-> !core_res.occupancy_map[core_res.slot_index])
        else $error("freed slot still marked in use");

endmodule

`default_nettype wire

@@ sv/fbpa_cfg.sv @@
`default_nettype none

module fbpa_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fbpa_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [fbpa_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [fbpa_pkg::ADDR_W-1:0]      pool_base
);
    import fbpa_pkg::*;

    localparam logic REG_POOL_BASE = 1'b0;

    logic                  reg_sel;
    logic                  wr_en;
    logic [ADDR_W-1:0]     pool_base_reg;

    // Word index of the register; byte lane bits are ignored
    assign reg_sel = paddr[CFG_ADDR_W-1];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg <= '0;
        end else if (wr_en && (reg_sel == REG_POOL_BASE)) begin
            pool_base_reg <= pwdata;
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_POOL_BASE: prdata = pool_base_reg;
            default:       prdata = '0;
        endcase
    end

    assign pool_base = pool_base_reg;

endmodule

`default_nettype wire

@@ sv/fbpa_core.sv @@
`default_nettype none

module fbpa_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  fbpa_pkg::req_t               req,
    input  logic [fbpa_pkg::ADDR_W-1:0]  pool_base,
    output fbpa_pkg::res_t               res
);
    import fbpa_pkg::*;

    slot_map_t                    used_reg;
    slot_map_t                    used_next;
    slot_map_t                    free_map;
    slot_map_t                    alloc_onehot;
    slot_map_t                    addr_hit;
    slot_map_t                    hit_onehot;
    slot_idx_t                    alloc_idx;
    slot_idx_t                    hit_idx;
    slot_idx_t                    res_idx;
    logic [ADDR_W-1:0]            offset;
    logic                         too_large;
    logic [SLOT_IDX_W+OUT_IDX_W-1:0] idx_wide;
    logic [NUM_SLOTS+OCC_W-1:0]   occ_wide;

    // Lowest free slot and lowest slot whose base equals the address
    always_comb begin
        free_map     = ~used_reg;
        alloc_onehot = free_map & (~free_map + slot_map_t'(1));
        offset       = req.block_address - pool_base;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            addr_hit[i] = (offset == slot_offset(SLOT_IDX_W'(i)));
        end
        hit_onehot = addr_hit & (~addr_hit + slot_map_t'(1));
        alloc_idx  = '0;
        hit_idx    = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (alloc_onehot[i]) alloc_idx = alloc_idx | SLOT_IDX_W'(i);
            if (hit_onehot[i])   hit_idx   = hit_idx | SLOT_IDX_W'(i);
        end
    end

    assign too_large = req.request_size > SIZE_W'(SLOT_BYTES);

    always_comb begin
        used_next        = used_reg;
        res.status       = ST_OK;
        res.slot_address = '0;
        res_idx          = '0;
        unique case (req.func)
            FUNC_ALLOC: begin
                if (too_large) begin
                    res.status = ST_TOO_LARGE;
                end else if (alloc_onehot == '0) begin
                    res.status = ST_NO_MEMORY;
                end else begin
                    used_next        = used_reg | alloc_onehot;
                    res.slot_address = pool_base + slot_offset(alloc_idx);
                    res_idx          = alloc_idx;
                end
            end
            FUNC_FREE: begin
                if (hit_onehot == '0) begin
                    res.status = ST_INVALID;
                end else if ((used_reg & hit_onehot) == '0) begin
                    res.status = ST_DOUBLE_FREE;
                end else begin
                    used_next = used_reg & ~hit_onehot;
                    res_idx   = hit_idx;
                end
            end
            default: res.status = ST_INVALID;
        endcase
        idx_wide          = (SLOT_IDX_W+OUT_IDX_W)'(res_idx);
        res.slot_index    = idx_wide[OUT_IDX_W-1:0];
        occ_wide          = (NUM_SLOTS+OCC_W)'(used_next);
        res.occupancy_map = occ_wide[OCC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (step) begin
            used_reg <= used_next;
        end
    end

endmodule

`default_nettype wire
